// File: sv/mfte_pkg.sv
// Shared types and constants for the motion-JPEG frame extractor.
`default_nettype none

package mfte_pkg;

    // Marker bytes and their codes
    localparam logic [7:0] BYTE_MARK   = 8'hFF;
    localparam logic [7:0] BYTE_SOI    = 8'hD8;
    localparam logic [7:0] BYTE_EOI    = 8'hD9;
    localparam logic [7:0] BYTE_COM    = 8'hFE;
    localparam logic [7:0] BYTE_TSFLAG = 8'h01;

    // One hundredth of a second in nanoseconds
    localparam logic [31:0] NS_PER_HUNDREDTH = 32'd10000000;

    // Last index of the four-byte header and seconds fields
    localparam logic [1:0] FIELD_LAST = 2'd3;

    // Depth of the queue between parser and emitter
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_SEARCH     = 3'd0,
        PH_SEARCH_FF  = 3'd1,
        PH_BODY       = 3'd2,
        PH_BODY_FF    = 3'd3,
        PH_HEADER     = 3'd4,
        PH_SECONDS    = 3'd5,
        PH_HUNDREDTHS = 3'd6
    } t_phase;

    // One queued command: a byte to send, possibly preceded by FF (start)
    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        logic        last;
        logic [31:0] seconds;
        logic [7:0]  hundredths;
    } t_cmd;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

endpackage

`default_nettype wire

// File: sv/mfte_parser.sv
// Front end: parses the byte stream and queues bytes to be sent.
`default_nettype none

module mfte_parser
    import mfte_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire t_q_stat    i_q_stat,
    output logic            o_ready,
    output logic            o_push,
    output t_cmd            o_cmd
);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_cnt, n_cnt;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_held_sec, n_held_sec;
    logic [7:0]  r_held_hund, n_held_hund;
    logic        accept;
    logic        emit;
    logic        is_start;
    logic        is_end;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                PH_SEARCH_FF: n_phase = (i_byte == BYTE_SOI) ? PH_BODY : PH_SEARCH;
                PH_BODY: begin
                    if (i_byte == BYTE_MARK) n_phase = PH_BODY_FF;
                end
                PH_BODY_FF: begin
                    if (i_byte == BYTE_EOI)      n_phase = PH_SEARCH;
                    else if (i_byte == BYTE_COM) n_phase = PH_HEADER;
                    else                         n_phase = PH_BODY;
                end
                PH_HEADER: begin
                    if (r_cnt == FIELD_LAST)
                        n_phase = (i_byte == BYTE_TSFLAG) ? PH_SECONDS : PH_BODY;
                end
                PH_SECONDS: begin
                    if (r_cnt == FIELD_LAST) n_phase = PH_HUNDREDTHS;
                end
                PH_HUNDREDTHS: n_phase = PH_BODY;
                default:       n_phase = (i_byte == BYTE_MARK) ? PH_SEARCH_FF : PH_SEARCH;
            endcase
        end
    end

    // Outputs and field assembly
    always_comb begin
        emit        = 1'b0;
        is_start    = 1'b0;
        is_end      = 1'b0;
        n_cnt       = r_cnt;
        n_shift     = r_shift;
        n_held_sec  = r_held_sec;
        n_held_hund = r_held_hund;
        unique case (r_phase)
            PH_SEARCH_FF: begin
                if (i_byte == BYTE_SOI) begin
                    emit        = 1'b1;
                    is_start    = 1'b1;
                    n_cnt       = '0;
                    n_shift     = '0;
                    n_held_sec  = '0;
                    n_held_hund = '0;
                end
            end
            PH_BODY: emit = 1'b1;
            PH_BODY_FF: begin
                emit   = 1'b1;
                is_end = (i_byte == BYTE_EOI);
                if (i_byte == BYTE_COM) n_cnt = '0;
            end
            PH_HEADER: begin
                emit  = 1'b1;
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == FIELD_LAST && i_byte == BYTE_TSFLAG) n_shift = '0;
            end
            PH_SECONDS: begin
                emit    = 1'b1;
                n_cnt   = r_cnt + 2'd1;
                n_shift = {r_shift[23:0], i_byte};
            end
            PH_HUNDREDTHS: begin
                emit        = 1'b1;
                n_held_sec  = r_shift;
                n_held_hund = i_byte;
            end
            default: emit = 1'b0;
        endcase
    end

    assign o_push           = accept && emit;
    assign o_cmd.data       = i_byte;
    assign o_cmd.start      = is_start;
    assign o_cmd.last       = is_end;
    assign o_cmd.seconds    = r_held_sec;
    assign o_cmd.hundredths = r_held_hund;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEARCH;
            r_cnt       <= '0;
            r_shift     <= '0;
            r_held_sec  <= '0;
            r_held_hund <= '0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_shift     <= n_shift;
            r_held_sec  <= n_held_sec;
            r_held_hund <= n_held_hund;
        end
    end

endmodule

`default_nettype wire

// File: sv/mfte_queue.sv
// Small first-word-fall-through queue of parsed commands.
`default_nettype none

module mfte_queue
    import mfte_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_q_stat   o_stat,
    output t_cmd      o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.valid = (r_count != '0);
    assign o_cmd        = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && o_stat.valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: sv/mfte_emitter.sv
// Back end: turns queued commands into output transfers.
`default_nettype none

module mfte_emitter
    import mfte_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_q_stat i_q_stat,
    input  wire t_cmd   i_cmd,
    output logic        o_pop,
    input  wire logic   i_ready,
    output logic        o_valid,
    output logic [7:0]  o_byte,
    output logic        o_start,
    output logic        o_end,
    output logic [31:0] o_seconds,
    output logic [31:0] o_nanoseconds
);

    logic        r_valid;
    logic        r_half;
    logic [7:0]  r_byte;
    logic        r_start;
    logic        r_end;
    logic [31:0] r_seconds;
    logic [31:0] r_nanoseconds;
    logic        load;
    logic        lead_ff;
    logic [31:0] ns_value;

    assign load    = i_q_stat.valid && (!r_valid || i_ready);
    // Start command goes out as FF first, the queued D8 on the next load
    assign lead_ff = i_cmd.start && !r_half;
    assign o_pop   = load && !lead_ff;
    assign ns_value = 32'(i_cmd.hundredths) * NS_PER_HUNDREDTH;

    // Output valid and start-marker split
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load)          r_valid <= 1'b1;
            else if (i_ready)  r_valid <= 1'b0;
            if (load)          r_half  <= lead_ff;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte        <= lead_ff ? BYTE_MARK : i_cmd.data;
            r_start       <= lead_ff;
            r_end         <= i_cmd.last && !lead_ff;
            r_seconds     <= (i_cmd.last && !lead_ff) ? i_cmd.seconds : '0;
            r_nanoseconds <= (i_cmd.last && !lead_ff) ? ns_value : '0;
        end
    end

    assign o_valid       = r_valid;
    assign o_byte        = r_byte;
    assign o_start       = r_start;
    assign o_end         = r_end;
    assign o_seconds     = r_seconds;
    assign o_nanoseconds = r_nanoseconds;

endmodule

`default_nettype wire

// File: sv/mjpeg_frame_timestamp_extractor_core.sv
// Top level of the motion-JPEG frame extractor with camera timestamp.
// Takes one stream byte per transfer and sends out the bytes of each JPEG image from the
// FF D8 start marker through the FF D9 end marker; all other bytes are dropped. A comment
// segment (FF FE) whose fourth header byte is 01 carries a big-endian seconds count and a
// hundredths byte, which are reported on the end-marker transfer (tlast) as seconds and
// nanoseconds; tuser marks the FF of the start marker. A byte is taken every clock while
// the command queue (QUEUE_DEPTH entries) has room. Each queued byte leaves the output
// register as one transfer, except the start marker, which occupies the output for two
// transfers (FF, D8); the queue absorbs that extra transfer.
`default_nettype none

module mjpeg_frame_timestamp_extractor_core
    import mfte_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,  // [7:0] stream_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [71:0]      o_m_axis_tdata,  // [7:0] image_byte, [39:8] stamp_seconds,
                                              // [71:40] stamp_nanoseconds
    output logic             o_m_axis_tlast,  // image_end
    output logic             o_m_axis_tuser   // image_start
);

    t_q_stat     q_stat;
    t_cmd        push_cmd;
    t_cmd        head_cmd;
    logic        push;
    logic        pop;
    logic [7:0]  out_byte;
    logic [31:0] out_seconds;
    logic [31:0] out_ns;

    mfte_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_byte   (i_s_axis_tdata),
        .i_q_stat (q_stat),
        .o_ready  (o_s_axis_tready),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    mfte_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_cmd   (head_cmd)
    );

    mfte_emitter u_emitter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (q_stat),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .i_ready       (i_m_axis_tready),
        .o_valid       (o_m_axis_tvalid),
        .o_byte        (out_byte),
        .o_start       (o_m_axis_tuser),
        .o_end         (o_m_axis_tlast),
        .o_seconds     (out_seconds),
        .o_nanoseconds (out_ns)
    );

    assign o_m_axis_tdata = {out_ns, out_seconds, out_byte};

    // No push is ever offered to a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full))
        else $error("push into full queue");

    // Start marker leads with FF
    a_start_is_ff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[7:0] == BYTE_MARK))
        else $error("start transfer not FF");

    // A delivered start FF is followed by D8 at the next output transfer
    a_start_then_soi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tuser)
        |=> (!o_m_axis_tvalid || (o_m_axis_tdata[7:0] == BYTE_SOI && !o_m_axis_tuser)))
        else $error("start FF not followed by D8");

    // Stamp fields are zero away from the end byte
    a_stamp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> (o_m_axis_tdata[71:8] == '0))
        else $error("stamp nonzero on non-end transfer");

endmodule

`default_nettype wire
